// ----- rtl/gdic_pkg.sv -----
package gdic_pkg;

   // Field widths
   localparam int AxisW     = 16;
   localparam int TrigW     = 15;
   localparam int ButtonW   = 15;
   localparam int AlphaW    = 17;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 20;

   // Full-scale smoothing weight (alpha = 1.0)
   localparam logic [AlphaW-1:0] AlphaOne = 17'h10000;

   // Register reset values
   localparam logic [5:0]          AxisSelectReset   = 6'd1;
   localparam logic [1:0]          InvertModeReset   = 2'd0;
   localparam logic [TrigW-1:0]    DeadzoneReset     = 15'd1638;
   localparam logic [AlphaW-1:0]   AlphaReset        = 17'd13107;
   localparam logic [19:0]         ButtonSelectReset = 20'd8981;

   // Register indexes on the csr port
   typedef enum logic [CsrIndexW-1:0] {
      REG_AXIS_SELECT    = 3'd0,
      REG_INVERT_MODE    = 3'd1,
      REG_DEADZONE_LEVEL = 3'd2,
      REG_SMOOTH_ALPHA   = 3'd3,
      REG_BUTTON_SELECT  = 3'd4
   } csr_index_type;

   // Axis source codes; the two remaining codes select nothing
   typedef enum logic [2:0] {
      AXIS_LEFT_X     = 3'd0,
      AXIS_LEFT_Y     = 3'd1,
      AXIS_RIGHT_X    = 3'd2,
      AXIS_RIGHT_Y    = 3'd3,
      AXIS_LEFT_TRIG  = 3'd4,
      AXIS_RIGHT_TRIG = 3'd5
   } axis_code_type;

   localparam logic [3:0] ButtonNone = 4'd15;

   typedef struct packed {
      logic signed [AxisW-1:0] left_x;
      logic signed [AxisW-1:0] left_y;
      logic signed [AxisW-1:0] right_x;
      logic signed [AxisW-1:0] right_y;
      logic [TrigW-1:0]        left_trig;
      logic [TrigW-1:0]        right_trig;
   } sample_type;

   // Conditioned intent waiting for the smoothing stage
   typedef struct packed {
      logic signed [AxisW-1:0] lin;
      logic signed [AxisW-1:0] ang;
      logic                    boost;
      logic                    stop;
      logic                    pulse;
      logic                    toggle;
      logic                    hold;
      logic                    conn;
   } intent_type;

   // Select one axis of the sample; triggers are zero-extended
   function automatic logic signed [AxisW-1:0] pick_axis(sample_type s, logic [2:0] code);
      logic signed [AxisW-1:0] v;
      case (code)
         AXIS_LEFT_X:     v = s.left_x;
         AXIS_LEFT_Y:     v = s.left_y;
         AXIS_RIGHT_X:    v = s.right_x;
         AXIS_RIGHT_Y:    v = s.right_y;
         AXIS_LEFT_TRIG:  v = $signed({1'b0, s.left_trig});
         AXIS_RIGHT_TRIG: v = $signed({1'b0, s.right_trig});
         default:         v = '0;
      endcase
      return v;
   endfunction

   // Optional saturating negate, then deadzone
   function automatic logic signed [AxisW-1:0] condition(logic signed [AxisW-1:0] v_raw,
                                                         logic neg,
                                                         logic [TrigW-1:0] dz);
      logic signed [AxisW-1:0] v;
      logic [AxisW-1:0]        mag;
      v = v_raw;
      if (neg) begin
         v = (v_raw == 16'sh8000) ? 16'sh7fff : -v_raw;
      end
      // the most negative value reads as magnitude 0x8000
      mag = v[AxisW-1] ? (~v + 16'd1) : v;
      if (mag < {1'b0, dz}) begin
         v = '0;
      end
      return v;
   endfunction

   function automatic logic pick_button(logic [ButtonW-1:0] bits, logic [3:0] code);
      logic b;
      if (code == ButtonNone) begin
         b = 1'b0;
      end else begin
         b = bits[code];
      end
      return b;
   endfunction

endpackage

// ----- rtl/gamepad_drive_intent_conditioner_top.sv -----
// Gamepad drive intent conditioner.
// Request channel (req_*): one gamepad sample per word, valid/ready.
// Response channel (rsp_*): one drive intent per sample, in order.
// Config channel (csr_*): csr_index selects the register, csr_data carries
// its value in the low bits; always ready, write only while no word is in
// flight.
// An accepted sample passes through the input stage and the result register.
// Throughput: one sample per clock while the receiver keeps rsp_ready high;
// the input stage and the result register each hold one word, and the
// smoothing loop (one 18x17 multiply per axis plus an add) is combinational.
// A stalled receiver holds the result register; the input stage still takes
// one more word and then req_ready drops until the result is taken.
// Reset restores register defaults, clears the smoothing state and empties
// both stages.
module gamepad_drive_intent_conditioner_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // config
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gdic_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [gdic_pkg::CsrDataW-1:0]        csr_data,
   // request
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [gdic_pkg::AxisW-1:0]    req_left_x,
   input  logic signed [gdic_pkg::AxisW-1:0]    req_left_y,
   input  logic signed [gdic_pkg::AxisW-1:0]    req_right_x,
   input  logic signed [gdic_pkg::AxisW-1:0]    req_right_y,
   input  logic [gdic_pkg::TrigW-1:0]           req_left_trig,
   input  logic [gdic_pkg::TrigW-1:0]           req_right_trig,
   input  logic [gdic_pkg::ButtonW-1:0]         req_button_bits,
   input  logic                                 req_connected,
   // response
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gdic_pkg::AxisW-1:0]    rsp_linear_cmd,
   output logic signed [gdic_pkg::AxisW-1:0]    rsp_angular_cmd,
   output logic                                 rsp_boost_on,
   output logic                                 rsp_stop_on,
   output logic                                 rsp_pulse_on,
   output logic                                 rsp_toggle_on,
   output logic                                 rsp_hold_on
);

   logic [5:0]                        axis_sel_ff,   axis_sel_in;
   logic [1:0]                        invert_ff,     invert_in;
   logic [gdic_pkg::TrigW-1:0]        deadzone_ff,   deadzone_in;
   logic [gdic_pkg::AlphaW-1:0]       alpha_ff,      alpha_in;
   logic [19:0]                       btn_sel_ff,    btn_sel_in;

   logic                              a_vld_ff, a_vld_in;
   gdic_pkg::intent_type              a_item_ff, a_item_in;
   logic                              out_vld_ff, out_vld_in;
   gdic_pkg::intent_type              out_item_ff, out_item_in;

   gdic_pkg::sample_type              sample;
   logic                              req_take;
   logic                              out_free;
   logic                              a_adv;
   logic signed [gdic_pkg::AxisW-1:0] lin_next;
   logic signed [gdic_pkg::AxisW-1:0] ang_next;
   logic                              stop_now;

   // Handshake control
   assign csr_ready = 1'b1;
   assign out_free  = !out_vld_ff || rsp_ready;
   assign a_adv     = a_vld_ff && out_free;
   assign req_ready = !a_vld_ff || out_free;
   assign req_take  = req_valid && req_ready;

   // Config register writes
   always_comb begin
      axis_sel_in = axis_sel_ff;
      invert_in   = invert_ff;
      deadzone_in = deadzone_ff;
      alpha_in    = alpha_ff;
      btn_sel_in  = btn_sel_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gdic_pkg::REG_AXIS_SELECT:    axis_sel_in = csr_data[5:0];
            gdic_pkg::REG_INVERT_MODE:    invert_in   = csr_data[1:0];
            gdic_pkg::REG_DEADZONE_LEVEL: deadzone_in = csr_data[gdic_pkg::TrigW-1:0];
            gdic_pkg::REG_SMOOTH_ALPHA:   alpha_in    = csr_data[gdic_pkg::AlphaW-1:0];
            gdic_pkg::REG_BUTTON_SELECT:  btn_sel_in  = csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_sel_ff <= gdic_pkg::AxisSelectReset;
         invert_ff   <= gdic_pkg::InvertModeReset;
         deadzone_ff <= gdic_pkg::DeadzoneReset;
         alpha_ff    <= gdic_pkg::AlphaReset;
         btn_sel_ff  <= gdic_pkg::ButtonSelectReset;
      end else begin
         axis_sel_ff <= axis_sel_in;
         invert_ff   <= invert_in;
         deadzone_ff <= deadzone_in;
         alpha_ff    <= alpha_in;
         btn_sel_ff  <= btn_sel_in;
      end
   end

   // Select, negate and deadzone the axes; pick buttons; apply disconnect
   always_comb begin
      sample.left_x     = req_left_x;
      sample.left_y     = req_left_y;
      sample.right_x    = req_right_x;
      sample.right_y    = req_right_y;
      sample.left_trig  = req_left_trig;
      sample.right_trig = req_right_trig;

      a_item_in.lin    = gdic_pkg::condition(gdic_pkg::pick_axis(sample, axis_sel_ff[2:0]),
                                             invert_ff[0], deadzone_ff);
      a_item_in.ang    = gdic_pkg::condition(gdic_pkg::pick_axis(sample, axis_sel_ff[5:3]),
                                             invert_ff[1], deadzone_ff);
      a_item_in.conn   = req_connected;
      a_item_in.boost  = req_connected &&
                         gdic_pkg::pick_button(req_button_bits, btn_sel_ff[3:0]);
      a_item_in.stop   = !req_connected ||
                         gdic_pkg::pick_button(req_button_bits, btn_sel_ff[7:4]);
      a_item_in.pulse  = req_connected &&
                         gdic_pkg::pick_button(req_button_bits, btn_sel_ff[11:8]);
      a_item_in.toggle = req_connected &&
                         gdic_pkg::pick_button(req_button_bits, btn_sel_ff[15:12]);
      a_item_in.hold   = req_connected &&
                         gdic_pkg::pick_button(req_button_bits, btn_sel_ff[19:16]);
   end

   // Input stage valid
   always_comb begin
      a_vld_in = a_vld_ff;
      if (req_take) begin
         a_vld_in = 1'b1;
      end else if (a_adv) begin
         a_vld_in = 1'b0;
      end
   end

   // Smoothing lanes, each holding its own previous value
   gdic_smooth u_lin_smooth (
      .clock    (clock),
      .reset    (reset),
      .advance  (a_adv),
      .keep     (a_item_ff.conn),
      .cur      (a_item_ff.lin),
      .alpha    (alpha_ff),
      .next_val (lin_next)
   );

   gdic_smooth u_ang_smooth (
      .clock    (clock),
      .reset    (reset),
      .advance  (a_adv),
      .keep     (a_item_ff.conn),
      .cur      (a_item_ff.ang),
      .alpha    (alpha_ff),
      .next_val (ang_next)
   );

   // Result word: stop zeroes the commands
   assign stop_now = a_item_ff.stop;

   always_comb begin
      out_item_in     = a_item_ff;
      out_item_in.lin = stop_now ? '0 : lin_next;
      out_item_in.ang = stop_now ? '0 : ang_next;
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (a_adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_item_ff <= a_item_in;
      end
      if (a_adv) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_linear_cmd  = out_item_ff.lin;
   assign rsp_angular_cmd = out_item_ff.ang;
   assign rsp_boost_on    = out_item_ff.boost;
   assign rsp_stop_on     = out_item_ff.stop;
   assign rsp_pulse_on    = out_item_ff.pulse;
   assign rsp_toggle_on   = out_item_ff.toggle;
   assign rsp_hold_on     = out_item_ff.hold;

   a_stop_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_on |-> rsp_linear_cmd == '0 && rsp_angular_cmd == '0)
      else $error("stop word carries nonzero drive command");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && !out_free |=> a_vld_ff && $stable(a_item_ff))
      else $error("input stage lost or changed a blocked word");

   a_disc_flags: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && !a_item_ff.conn |-> a_item_ff.stop && !a_item_ff.boost &&
                                      !a_item_ff.pulse && !a_item_ff.toggle &&
                                      !a_item_ff.hold)
      else $error("disconnected word without safe flags");

endmodule

// ----- rtl/gdic_smooth.sv -----
module gdic_smooth (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 keep,
   input  logic signed [gdic_pkg::AxisW-1:0]    cur,
   input  logic [gdic_pkg::AlphaW-1:0]          alpha,
   output logic signed [gdic_pkg::AxisW-1:0]    next_val
);

   logic signed [gdic_pkg::AxisW-1:0]   prev_ff;
   logic signed [gdic_pkg::AxisW-1:0]   prev_in;
   logic [gdic_pkg::AlphaW-1:0]         alpha_eff;
   logic signed [gdic_pkg::AxisW:0]     diff;
   logic signed [34:0]                  prod;
   logic signed [34:0]                  rounded;
   logic signed [18:0]                  sum_wide;

   // Clamp the weight to 1.0
   assign alpha_eff = (alpha > gdic_pkg::AlphaOne) ? gdic_pkg::AlphaOne : alpha;

   // prev + round(alpha * (cur - prev) / 65536), ties toward plus infinity
   assign diff     = {cur[gdic_pkg::AxisW-1], cur} - {prev_ff[gdic_pkg::AxisW-1], prev_ff};
   assign prod     = $signed({1'b0, alpha_eff}) * diff;
   assign rounded  = prod + 35'sd32768;
   assign sum_wide = {{3{prev_ff[gdic_pkg::AxisW-1]}}, prev_ff} + rounded[34:16];
   assign next_val = sum_wide[gdic_pkg::AxisW-1:0];

   // Take the new value, or clear on disconnect
   always_comb begin
      prev_in = prev_ff;
      if (advance) begin
         prev_in = keep ? next_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   a_clear_on_drop: assert property (@(posedge clock) disable iff (reset)
      advance && !keep |=> prev_ff == '0)
      else $error("smoothing state not cleared on disconnect");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(prev_ff))
      else $error("smoothing state moved without an advancing word");

endmodule
